// ===== design/bsbc_pkg.sv =====
// Shared types, constants and register map for the battery side balance controller.
package bsbc_pkg;

    localparam int VOLT_WIDTH = 16;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);

    localparam logic [VOLT_WIDTH-1:0] VOLT_FULL = {VOLT_WIDTH{1'b1}};

    localparam logic [VOLT_WIDTH-1:0] RST_INIT_THR  = VOLT_WIDTH'(25000);
    localparam logic [VOLT_WIDTH-1:0] RST_MAX_THR   = VOLT_WIDTH'(27000);
    localparam logic [VOLT_WIDTH-1:0] RST_MIN_THR   = VOLT_WIDTH'(22000);
    localparam logic [VOLT_WIDTH-1:0] RST_RAISE_MRG = VOLT_WIDTH'(500);
    localparam logic [VOLT_WIDTH-1:0] RST_LOWER_MRG = VOLT_WIDTH'(500);
    localparam logic [VOLT_WIDTH-1:0] RST_RAISE_STP = VOLT_WIDTH'(250);
    localparam logic [VOLT_WIDTH-1:0] RST_LOWER_STP = VOLT_WIDTH'(250);
    localparam logic [VOLT_WIDTH-1:0] RST_LIFE_LVL  = VOLT_WIDTH'(21000);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INIT_THR  = 3'd0,
        REG_MAX_THR   = 3'd1,
        REG_MIN_THR   = 3'd2,
        REG_RAISE_MRG = 3'd3,
        REG_LOWER_MRG = 3'd4,
        REG_RAISE_STP = 3'd5,
        REG_LOWER_STP = 3'd6,
        REG_LIFE_LVL  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                  from_starboard;
        logic [VOLT_WIDTH-1:0] reading_mv;
    } t_in_item;

    typedef struct packed {
        logic                  charging_side;
        logic                  swapped;
        logic                  critical_mode;
        logic [VOLT_WIDTH-1:0] threshold_now;
    } t_out_item;

    typedef struct packed {
        logic [VOLT_WIDTH-1:0] initial_threshold;
        logic [VOLT_WIDTH-1:0] thr_ceiling;
        logic [VOLT_WIDTH-1:0] thr_floor;
        logic [VOLT_WIDTH-1:0] raise_margin;
        logic [VOLT_WIDTH-1:0] lower_margin;
        logic [VOLT_WIDTH-1:0] raise_step;
        logic [VOLT_WIDTH-1:0] lower_step;
        logic [VOLT_WIDTH-1:0] life_support_level;
    } t_cfg;

    // Direct load of the working threshold on an initial_threshold write.
    typedef struct packed {
        logic                  load;
        logic [VOLT_WIDTH-1:0] value;
    } t_thr_load;

endpackage

// ===== design/battery_side_balance_controller.sv =====
// Top level: input register, balance policy core, result register and config port.
//
// Usage:
//   Readings arrive on the input channel (i_in_valid / o_in_ready / i_in_item),
//   each a side flag and a voltage in millivolts. Every reading produces exactly
//   one result request on the output channel (o_out_valid / i_out_ready /
//   o_out_item): charging side, swap flag, critical mode flag and threshold.
//   Registers are written through i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data while the block is idle (a user rule the block does not enforce);
//   o_cfg_ready is always high. Writing initial_threshold also loads the working
//   threshold immediately. A reading accepted into the input register moves to the
//   result register when that is free or being taken. Throughput: one reading per
//   cycle while the receiver does not stall; the policy state is read and updated
//   between the two registers, so readings chain without bubbles.
//   When the receiver stalls, the result register holds and one more reading
//   may wait in the input register; o_in_ready drops only when both are full.
//   Reset (synchronous, active low) restores register defaults, regular mode,
//   port charging, threshold 25000 mV, both side voltages at full scale, and
//   empties both stages.
module battery_side_balance_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  bsbc_pkg::t_in_item                    i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output bsbc_pkg::t_out_item                   o_out_item,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bsbc_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [bsbc_pkg::VOLT_WIDTH-1:0]       i_cfg_data
);

    logic                r_in_valid;
    bsbc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    bsbc_pkg::t_out_item r_out_item;

    bsbc_pkg::t_cfg      cfg;
    bsbc_pkg::t_thr_load thr_load;
    bsbc_pkg::t_out_item result;

    logic advance;
    logic in_take;
    logic cfg_wr;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    bsbc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (cfg_wr),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg),
        .o_thr_load (thr_load)
    );

    bsbc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_item     (r_in_item),
        .i_cfg      (cfg),
        .i_thr_load (thr_load),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a pending reading is never dropped while the result stage is stalled
    a_hold_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid)
        else $error("pending reading lost during output stall");

    // every processed reading lands in the result register
    a_result_after_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed reading produced no result");

    // an empty input stage always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled while input stage empty");

endmodule

// ===== design/bsbc_regs.sv =====
// Configuration register file of the battery side balance controller.
module bsbc_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [bsbc_pkg::REG_IDX_W-1:0]        i_wr_index,
    input  logic [bsbc_pkg::VOLT_WIDTH-1:0]       i_wr_data,
    output bsbc_pkg::t_cfg                        o_cfg,
    output bsbc_pkg::t_thr_load                   o_thr_load
);

    bsbc_pkg::t_cfg r_cfg;
    bsbc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (bsbc_pkg::t_reg_idx'(i_wr_index))
                bsbc_pkg::REG_INIT_THR:  n_cfg.initial_threshold  = i_wr_data;
                bsbc_pkg::REG_MAX_THR:   n_cfg.thr_ceiling        = i_wr_data;
                bsbc_pkg::REG_MIN_THR:   n_cfg.thr_floor          = i_wr_data;
                bsbc_pkg::REG_RAISE_MRG: n_cfg.raise_margin       = i_wr_data;
                bsbc_pkg::REG_LOWER_MRG: n_cfg.lower_margin       = i_wr_data;
                bsbc_pkg::REG_RAISE_STP: n_cfg.raise_step         = i_wr_data;
                bsbc_pkg::REG_LOWER_STP: n_cfg.lower_step         = i_wr_data;
                bsbc_pkg::REG_LIFE_LVL:  n_cfg.life_support_level = i_wr_data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_threshold  <= bsbc_pkg::RST_INIT_THR;
            r_cfg.thr_ceiling        <= bsbc_pkg::RST_MAX_THR;
            r_cfg.thr_floor          <= bsbc_pkg::RST_MIN_THR;
            r_cfg.raise_margin       <= bsbc_pkg::RST_RAISE_MRG;
            r_cfg.lower_margin       <= bsbc_pkg::RST_LOWER_MRG;
            r_cfg.raise_step         <= bsbc_pkg::RST_RAISE_STP;
            r_cfg.lower_step         <= bsbc_pkg::RST_LOWER_STP;
            r_cfg.life_support_level <= bsbc_pkg::RST_LIFE_LVL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg            = r_cfg;
    assign o_thr_load.load  = i_wr_en &&
                              (bsbc_pkg::t_reg_idx'(i_wr_index) == bsbc_pkg::REG_INIT_THR);
    assign o_thr_load.value = i_wr_data;

endmodule

// ===== design/bsbc_core.sv =====
// Balance policy: side voltages, mode and threshold state plus next-state logic.
module bsbc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  bsbc_pkg::t_in_item    i_item,
    input  bsbc_pkg::t_cfg        i_cfg,
    input  bsbc_pkg::t_thr_load   i_thr_load,
    output bsbc_pkg::t_out_item   o_result
);

    localparam int VW = bsbc_pkg::VOLT_WIDTH;

    logic          r_critical;
    logic [VW-1:0] r_threshold;
    logic          r_charge_side;
    logic [VW-1:0] r_port_mv;
    logic [VW-1:0] r_stbd_mv;

    logic          n_critical;
    logic [VW-1:0] n_threshold;
    logic          n_charge_side;

    logic [VW-1:0] other_mv;
    logic [VW:0]   full_level;
    logic [VW:0]   low_band;
    logic [VW:0]   raised;
    logic          swap;
    logic          from_charging;

    always_comb begin
        other_mv      = i_item.from_starboard ? r_port_mv : r_stbd_mv;
        // sums carry one extra bit so they never wrap
        full_level    = {1'b0, r_threshold} + {1'b0, i_cfg.raise_margin};
        low_band      = {1'b0, r_threshold} + {1'b0, i_cfg.lower_margin};
        raised        = {1'b0, r_threshold} + {1'b0, i_cfg.raise_step};
        from_charging = (i_item.from_starboard == r_charge_side);

        swap        = 1'b0;
        n_critical  = r_critical;
        n_threshold = r_threshold;

        if (!r_critical) begin
            if (from_charging) begin
                if (({1'b0, i_item.reading_mv} >= full_level) &&
                    (r_threshold < i_cfg.thr_ceiling)) begin
                    swap        = 1'b1;
                    n_threshold = raised[VW] ? bsbc_pkg::VOLT_FULL : raised[VW-1:0];
                end
            end else if (i_item.reading_mv <= r_threshold) begin
                swap = 1'b1;
                if ({1'b0, other_mv} <= low_band) begin
                    if (r_threshold > i_cfg.thr_floor) begin
                        n_threshold = (i_cfg.lower_step >= r_threshold) ? '0
                                    : r_threshold - i_cfg.lower_step;
                    end else begin
                        n_critical = 1'b1;
                    end
                end
            end
        end else begin
            if (from_charging) begin
                if ({1'b0, i_item.reading_mv} >= full_level) begin
                    swap       = 1'b1;
                    n_critical = 1'b0;
                end
            end else if (i_item.reading_mv <= i_cfg.life_support_level) begin
                swap = 1'b1;
            end
        end

        n_charge_side = r_charge_side ^ swap;

        o_result.charging_side = n_charge_side;
        o_result.swapped       = swap;
        o_result.critical_mode = n_critical;
        o_result.threshold_now = n_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_critical    <= 1'b0;
            r_threshold   <= bsbc_pkg::RST_INIT_THR;
            r_charge_side <= 1'b0;
            r_port_mv     <= bsbc_pkg::VOLT_FULL;
            r_stbd_mv     <= bsbc_pkg::VOLT_FULL;
        end else if (i_thr_load.load) begin
            r_threshold <= i_thr_load.value;
        end else if (i_advance) begin
            r_critical    <= n_critical;
            r_threshold   <= n_threshold;
            r_charge_side <= n_charge_side;
            if (i_item.from_starboard) begin
                r_stbd_mv <= i_item.reading_mv;
            end else begin
                r_port_mv <= i_item.reading_mv;
            end
        end
    end

endmodule
